// ===== hdl/ppe_pkg.sv =====
// ----------------------------------------------------------------------------
// Piecewise polynomial evaluator package
// Shared widths, opcodes and saturation helper.
// ----------------------------------------------------------------------------
package ppe_pkg;

   localparam int MAX_AXES         = 4;
   localparam int MAX_SEGMENTS     = 64;
   localparam int MAX_COEFFICIENTS = 8;

   localparam int AXIS_W  = 2;
   localparam int SEG_W   = 6;
   localparam int COEF_W  = 3;
   localparam int VAL_W   = 32;
   localparam int RES_W   = 48;
   localparam int START_W = 40;
   localparam int NUM_W   = 56;

   localparam logic [1:0] OP_LOAD_COEF = 2'd0;
   localparam logic [1:0] OP_LOAD_DUR  = 2'd1;
   localparam logic [1:0] OP_EVAL      = 2'd2;

   localparam logic [1:0] REG_AXES  = 2'd0;
   localparam logic [1:0] REG_SEGS  = 2'd1;
   localparam logic [1:0] REG_COEFS = 2'd2;

   function automatic logic signed [RES_W-1:0] sat48(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_7FFF_FFFF_FFFF;
      lo = -64'sh0000_8000_0000_0000;
      if (v > hi) begin
         sat48 = hi[RES_W-1:0];
      end else if (v < lo) begin
         sat48 = lo[RES_W-1:0];
      end else begin
         sat48 = v[RES_W-1:0];
      end
   endfunction

endpackage

// ===== hdl/piecewise_polynomial_evaluator.sv =====
// ----------------------------------------------------------------------------
// Piecewise polynomial evaluator
// Per-axis segment search, normalizing divide, derivative and Horner sum.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat is a coefficient load, a duration load or an
//   evaluate request (kind in req_tuser). Loads complete in the beat cycle
//   and give no result. An evaluate gives one rsp beat per axis in use,
//   axis 0 first, with rsp_tlast on the final axis.
//   csr port: write axes, segments and coefficients in use while idle.
//   Steps per axis: walk the segments, run the bit-serial normalizing
//   divider (skipped for zero duration), then per coefficient load it,
//   apply each derivative step and, on every coefficient below the highest,
//   do the split Horner multiply and sum, and last hand over the result. A
//   request whose order is beyond the degree skips the walk and the divide
//   and gives zero on every axis.
//   The coefficient and duration memories each have a write port and a
//   registered read port; an evaluate holds req_tready low until its last
//   axis is handed to the output register.
//   Reset sets the registers to 3 axes, 1 segment, 8 coefficients; memory
//   contents stay undefined until loaded.
//   A stalled receiver holds the output register; the sequencer waits.
// ----------------------------------------------------------------------------
module piecewise_polynomial_evaluator
   import ppe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // axis_index, segment_index, coefficient_index, load_value, eval_time,
   // derivative_order, zero fill
   input  logic [79:0]  req_tdata,
   // opcode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_value
   output logic [47:0]  rsp_tdata,
   // result_axis
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [6:0]   csr_wdata
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SEG_WAIT = 4'd1;
   localparam logic [3:0] ST_SEG_CHK  = 4'd2;
   localparam logic [3:0] ST_DIV      = 4'd3;
   localparam logic [3:0] ST_CLAMP    = 4'd4;
   localparam logic [3:0] ST_CF_WAIT  = 4'd5;
   localparam logic [3:0] ST_CF_LOAD  = 4'd6;
   localparam logic [3:0] ST_DIFF     = 4'd7;
   localparam logic [3:0] ST_ACC      = 4'd8;
   localparam logic [3:0] ST_MUL_LO   = 4'd9;
   localparam logic [3:0] ST_MUL_HI   = 4'd10;
   localparam logic [3:0] ST_SUM      = 4'd11;
   localparam logic [3:0] ST_EMIT     = 4'd12;

   logic [AXIS_W-1:0] ld_axis;
   logic [SEG_W-1:0]  ld_seg;
   logic [COEF_W-1:0] ld_coef;
   logic [VAL_W-1:0]  ld_value;
   logic [31:0]       ld_time;
   logic [2:0]        ld_order;

   assign ld_axis  = req_tdata[1:0];
   assign ld_seg   = req_tdata[7:2];
   assign ld_coef  = req_tdata[10:8];
   assign ld_value = req_tdata[42:11];
   assign ld_time  = req_tdata[74:43];
   assign ld_order = req_tdata[77:75];

   logic [2:0] axes_ff, axes_in;
   logic [6:0] segs_ff, segs_in;
   logic [3:0] coefs_ff, coefs_in;

   logic [2:0] naxes;
   logic [6:0] nseg;
   logic [3:0] ncoef;

   assign naxes = (axes_ff == 3'd0) ? 3'd1 :
                  (axes_ff > 3'(MAX_AXES)) ? 3'(MAX_AXES) : axes_ff;
   assign nseg  = (segs_ff == 7'd0) ? 7'd1 :
                  (segs_ff > 7'(MAX_SEGMENTS)) ? 7'(MAX_SEGMENTS) : segs_ff;
   assign ncoef = (coefs_ff == 4'd0) ? 4'd1 :
                  (coefs_ff > 4'(MAX_COEFFICIENTS)) ? 4'(MAX_COEFFICIENTS) : coefs_ff;

   logic [VAL_W-1:0] coef_mem [MAX_AXES*MAX_SEGMENTS*MAX_COEFFICIENTS];
   logic [VAL_W-1:0] dur_mem  [MAX_AXES*MAX_SEGMENTS];
   logic [VAL_W-1:0] coef_q_ff;
   logic [VAL_W-1:0] dur_q_ff;

   logic [3:0]                state_ff, state_in;
   logic [AXIS_W-1:0]         axis_ff, axis_in;
   logic [SEG_W-1:0]          seg_ff, seg_in;
   logic signed [START_W-1:0] start_ff, start_in;
   logic [31:0]               time_ff, time_in;
   logic [2:0]                order_ff, order_in;
   logic [NUM_W-1:0]          num_ff, num_in;
   logic [32:0]               rem_ff, rem_in;
   logic [31:0]               den_ff, den_in;
   logic                      neg_ff, neg_in;
   logic [5:0]                cnt_ff, cnt_in;
   logic signed [31:0]        s_ff, s_in;
   logic [COEF_W-1:0]         jj_ff, jj_in;
   logic [2:0]                k_ff, k_in;
   logic signed [RES_W-1:0]   dc_ff, dc_in;
   logic signed [RES_W-1:0]   acc_ff, acc_in;
   logic                      first_ff, first_in;
   logic signed [64:0]        plo_ff, plo_in;
   logic signed [47:0]        phi_ff, phi_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [AXIS_W-1:0]         rsp_axis_ff, rsp_axis_in;
   logic [RES_W-1:0]          rsp_value_ff, rsp_value_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      req_fire;
   logic [COEF_W-1:0]         cidx;
   logic [3:0]                jj_init;
   logic signed [31:0]        dur_s;
   logic signed [START_W-1:0] time_s;
   logic signed [START_W-1:0] seg_end;
   logic signed [START_W-1:0] diff;
   logic [START_W-1:0]        diff_mag;
   logic [32:0]               rem_sh;
   logic signed [51:0]        diff_prod;
   logic [2:0]                factor;
   logic signed [79:0]        prod;
   logic signed [63:0]        horner;
   logic                      skip;
   logic                      out_free;

   assign req_fire = req_tvalid && req_tready;
   assign cidx     = COEF_W'(jj_ff + order_ff);
   assign jj_init  = ncoef - 4'd1 - {1'b0, order_ff};
   assign skip     = {1'b0, order_ff} >= ncoef;
   assign dur_s    = $signed(dur_q_ff);
   assign time_s   = $signed({{(START_W-32){1'b0}}, time_ff});
   assign seg_end  = start_ff + START_W'(dur_s);
   assign diff     = time_s - start_ff;
   assign diff_mag = diff[START_W-1] ? START_W'(-diff) : diff;
   assign rem_sh   = {rem_ff[31:0], num_ff[NUM_W-1]};
   assign factor   = cidx - k_ff;
   assign diff_prod = dc_ff * $signed({1'b0, factor});
   assign prod     = $signed({phi_ff, 32'd0}) + 80'(plo_ff);
   assign horner   = $signed(prod[79:16]) + 64'(dc_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_axis_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == OP_LOAD_COEF) begin
         coef_mem[{ld_axis, ld_seg, ld_coef}] <= ld_value;
      end
      if (req_fire && req_tuser == OP_LOAD_DUR) begin
         dur_mem[{ld_axis, ld_seg}] <= ld_value;
      end
      coef_q_ff <= coef_mem[{axis_ff, seg_ff, cidx}];
      dur_q_ff  <= dur_mem[{axis_ff, seg_ff}];
   end

   always_comb begin
      axes_in  = axes_ff;
      segs_in  = segs_ff;
      coefs_in = coefs_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_AXES:  axes_in  = csr_wdata[2:0];
            REG_SEGS:  segs_in  = csr_wdata;
            REG_COEFS: coefs_in = csr_wdata[3:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      seg_in       = seg_ff;
      start_in     = start_ff;
      time_in      = time_ff;
      order_in     = order_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      s_in         = s_ff;
      jj_in        = jj_ff;
      k_in         = k_ff;
      dc_in        = dc_ff;
      acc_in       = acc_ff;
      first_in     = first_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_axis_in  = rsp_axis_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser == OP_EVAL) begin
               time_in  = ld_time;
               order_in = ld_order;
               axis_in  = '0;
               seg_in   = '0;
               start_in = '0;
               acc_in   = '0;
               state_in = ({1'b0, ld_order} >= ncoef) ? ST_EMIT : ST_SEG_WAIT;
            end
         end
         ST_SEG_WAIT: state_in = ST_SEG_CHK;
         ST_SEG_CHK: begin
            if ({1'b0, seg_ff} == nseg - 7'd1 || time_s < seg_end) begin
               den_in   = dur_s[31] ? 32'(-dur_s) : dur_s;
               neg_in   = diff[START_W-1] ^ dur_s[31];
               num_in   = {diff_mag, 16'd0};
               rem_in   = '0;
               cnt_in   = '0;
               s_in     = '0;
               jj_in    = jj_init[COEF_W-1:0];
               first_in = 1'b1;
               state_in = (dur_s == 32'sd0) ? ST_CF_WAIT : ST_DIV;
            end else begin
               start_in = seg_end;
               seg_in   = seg_ff + SEG_W'(1);
               state_in = ST_SEG_WAIT;
            end
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(NUM_W-1)) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (!neg_ff) begin
               s_in = (num_ff > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF :
                      $signed(num_ff[31:0]);
            end else begin
               s_in = (num_ff > NUM_W'(33'h0_8000_0000)) ? 32'sh8000_0000 :
                      $signed(32'(-num_ff[31:0]));
            end
            state_in = ST_CF_WAIT;
         end
         ST_CF_WAIT: state_in = ST_CF_LOAD;
         ST_CF_LOAD: begin
            dc_in    = RES_W'($signed(coef_q_ff));
            k_in     = '0;
            state_in = (order_ff == 3'd0) ? ST_ACC : ST_DIFF;
         end
         ST_DIFF: begin
            dc_in = sat48(64'(diff_prod));
            k_in  = k_ff + 3'd1;
            if (k_ff == order_ff - 3'd1) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (first_ff) begin
               acc_in   = dc_ff;
               first_in = 1'b0;
               if (jj_ff == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  jj_in    = jj_ff - COEF_W'(1);
                  state_in = ST_CF_WAIT;
               end
            end else begin
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            plo_in   = $signed({1'b0, acc_ff[31:0]}) * s_ff;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            phi_in   = $signed(acc_ff[47:32]) * s_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc_in = sat48(horner);
            if (jj_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               jj_in    = jj_ff - COEF_W'(1);
               state_in = ST_CF_WAIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_axis_in  = axis_ff;
               rsp_value_in = acc_ff;
               rsp_last_in  = ({1'b0, axis_ff} == naxes - 3'd1);
               if ({1'b0, axis_ff} == naxes - 3'd1) begin
                  state_in = ST_IDLE;
               end else begin
                  axis_in  = axis_ff + AXIS_W'(1);
                  seg_in   = '0;
                  start_in = '0;
                  acc_in   = '0;
                  state_in = skip ? ST_EMIT : ST_SEG_WAIT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         axes_ff      <= 3'd3;
         segs_ff      <= 7'd1;
         coefs_ff     <= 4'd8;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         axes_ff      <= axes_in;
         segs_ff      <= segs_in;
         coefs_ff     <= coefs_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff      <= axis_in;
      seg_ff       <= seg_in;
      start_ff     <= start_in;
      time_ff      <= time_in;
      order_ff     <= order_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      neg_ff       <= neg_in;
      cnt_ff       <= cnt_in;
      s_ff         <= s_in;
      jj_ff        <= jj_in;
      k_ff         <= k_in;
      dc_ff        <= dc_in;
      acc_ff       <= acc_in;
      first_ff     <= first_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      rsp_axis_ff  <= rsp_axis_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   a_last_axis: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && {1'b0, axis_ff} == naxes - 3'd1)
      |=> (rsp_tvalid && rsp_tlast && state_ff == ST_IDLE))
      else $error("last beat not flagged on final axis");

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEG_CHK) |-> ({1'b0, seg_ff} < nseg))
      else $error("segment walk past segments in use");

   a_diff_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF) |-> (k_ff < order_ff))
      else $error("derivative step count overrun");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Piecewise polynomial evaluator testbench
// Loads coefficient and duration tables, then sends evaluate requests under
// several axis, segment and coefficient settings. A built-in trajectory
// predictor computes each axis value, and every result beat is checked
// field by field against it. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import ppe_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE      = 20;

   typedef struct {
      logic [1:0]  op;
      logic [1:0]  ax;
      logic [5:0]  sg;
      logic [2:0]  cf;
      logic [31:0] val;
      logic [31:0] tim;
      logic [2:0]  ord;
   } traj_req_type;

   typedef struct {
      logic [1:0]  ax;
      logic [47:0] value;
      logic        last;
   } axis_result_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 0;
   logic [1:0]  csr_addr = '0;
   logic [6:0]  csr_wdata = '0;

   traj_req_type    pend_q[$];
   axis_result_type axis_results_q[$];

   logic [31:0] coef_mem[MAX_AXES][MAX_SEGMENTS][MAX_COEFFICIENTS];
   logic [31:0] dur_mem[MAX_AXES][MAX_SEGMENTS];
   bit          coef_ok[MAX_AXES][MAX_SEGMENTS][MAX_COEFFICIENTS];
   bit          dur_ok[MAX_AXES][MAX_SEGMENTS];
   int          cfg_axes = 3;
   int          cfg_segs = 1;
   int          cfg_coefs = 8;

   traj_req_type cur_req;
   int        send_gap = 0;
   int        rsp_gap = 0;
   int        hold_cnt = 0;
   bit        hold_done = 0;
   int        rsp_seen = 0;
   int        idle_cnt = 0;
   int        errors = 0;

   piecewise_polynomial_evaluator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint sat_q48(longint v);
      if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
      if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
      return v;
   endfunction

   function automatic longint axis_position(int a, longint t, int ord);
      int     nseg;
      int     ncoef;
      int     seg;
      int     m;
      longint start;
      longint dur;
      longint s;
      longint acc;
      longint v;
      longint lo;
      longint hi;
      longint dc[MAX_COEFFICIENTS];
      nseg = clamp_int(cfg_segs, 1, MAX_SEGMENTS);
      ncoef = clamp_int(cfg_coefs, 1, MAX_COEFFICIENTS);
      start = 0;
      dur = 0;
      for (seg = 0; seg < nseg; seg++) begin
         dur = longint'($signed(dur_mem[a][seg]));
         if (seg == nseg - 1 || t < start + dur) break;
         start += dur;
      end
      if (ord >= ncoef) return 0;
      if (dur == 0) begin
         s = 0;
      end else begin
         s = ((t - start) * 65536) / dur;
         if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
         if (s < -64'sh8000_0000) s = -64'sh8000_0000;
      end
      m = ncoef - ord;
      for (int j = 0; j < m; j++) begin
         v = longint'($signed(coef_mem[a][seg][j + ord]));
         for (int k = 0; k < ord; k++) v = sat_q48(v * longint'(j + ord - k));
         dc[j] = v;
      end
      acc = dc[m - 1];
      for (int j = m - 1; j > 0; j--) begin
         lo = s & 64'hFFFF;
         hi = (s - lo) / 65536;
         acc = sat_q48(acc * hi + ((acc * lo) >>> 16) + dc[j - 1]);
      end
      return acc;
   endfunction

   function automatic void apply_request(traj_req_type r);
      int naxes;
      axis_result_type e;
      case (r.op)
         OP_LOAD_COEF: coef_mem[r.ax][r.sg][r.cf] = r.val;
         OP_LOAD_DUR: dur_mem[r.ax][r.sg] = r.val;
         OP_EVAL: begin
            naxes = clamp_int(cfg_axes, 1, MAX_AXES);
            for (int a = 0; a < naxes; a++) begin
               e.ax = a[1:0];
               e.value = 48'(axis_position(a, longint'(r.tim), int'(r.ord)));
               e.last = (a == naxes - 1);
               axis_results_q.insert(axis_results_q.size(), e);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [79:0] pack_req(traj_req_type r);
      return {2'b00, r.ord, r.tim, r.val, r.cf, r.sg, r.ax};
   endfunction

   // driver
   always @(posedge clock) begin
      int g;
      if (reset) begin
         req_tvalid <= 0;
         send_gap <= 0;
      end else if (req_tvalid && req_tready) begin
         apply_request(cur_req);
         g = $urandom_range(0, 3);
         if (g == 0 && pend_q.size() > 0) begin
            cur_req = pend_q.pop_front();
            req_tdata <= pack_req(cur_req);
            req_tuser <= cur_req.op;
         end else begin
            req_tvalid <= 0;
            send_gap <= g;
         end
      end else if (!req_tvalid) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else if (pend_q.size() > 0) begin
            cur_req = pend_q.pop_front();
            req_tdata <= pack_req(cur_req);
            req_tuser <= cur_req.op;
            req_tvalid <= 1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      axis_result_type e;
      int stall;
      if (reset) begin
         rsp_tready <= 0;
         rsp_gap <= 0;
      end else begin
         stall = rsp_gap;
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen <= rsp_seen + 1;
            if (axis_results_q.size() == 0) begin
               $display("%0t: unexpected result beat axis=%0d value=%h last=%b",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               e = axis_results_q.pop_front();
               if (e.ax !== rsp_tuser) begin
                  $display("%0t: axis mismatch expected %0d actual %0d",
                           $time, e.ax, rsp_tuser);
                  errors++;
               end
               if (e.value !== rsp_tdata) begin
                  $display("%0t: value mismatch axis %0d expected %h actual %h",
                           $time, e.ax, e.value, rsp_tdata);
                  errors++;
               end
               if (e.last !== rsp_tlast) begin
                  $display("%0t: last mismatch axis %0d expected %b actual %b",
                           $time, e.ax, e.last, rsp_tlast);
                  errors++;
               end
            end
            stall = $urandom_range(0, 3);
            if (rsp_seen == 40 && !hold_done) begin
               hold_done <= 1;
               hold_cnt <= 400;
            end
         end
         if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_tready <= 0;
            rsp_gap <= stall;
         end else if (stall > 0) begin
            rsp_tready <= 0;
            rsp_gap <= stall - 1;
         end else begin
            rsp_tready <= 1;
            rsp_gap <= 0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cnt <= 0;
      end else if (idle_cnt >= STALL_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         idle_cnt <= idle_cnt + 1;
      end
   end

   task automatic push_req(logic [1:0] op, int ax, int sg, int cf, logic [31:0] val,
                           logic [31:0] tim, int ord);
      traj_req_type r;
      r.op = op;
      r.ax = ax[1:0];
      r.sg = sg[5:0];
      r.cf = cf[2:0];
      r.val = val;
      r.tim = tim;
      r.ord = ord[2:0];
      if (op == OP_LOAD_COEF) coef_ok[r.ax][r.sg][r.cf] = 1;
      if (op == OP_LOAD_DUR) dur_ok[r.ax][r.sg] = 1;
      pend_q.insert(pend_q.size(), r);
   endtask

   function automatic logic [31:0] pick_duration();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 32'd0;
      if (r == 1) return -$urandom_range(32'h100, 32'h20000);
      if (r == 2) return $urandom;
      return $urandom_range(32'h800, 32'h30000);
   endfunction

   function automatic logic [31:0] pick_coef();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 32'h7FFF_FFFF;
      if (r == 1) return 32'h8000_0000;
      if (r < 8) return $urandom;
      return $urandom_range(0, 32'h40000) - 32'h20000;
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (pend_q.size() > 0 || req_tvalid || axis_results_q.size() > 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] addr, int value);
      @(posedge clock);
      csr_we <= 1;
      csr_addr <= addr;
      csr_wdata <= value[6:0];
      @(posedge clock);
      csr_we <= 0;
      case (addr)
         REG_AXES: cfg_axes = value & 7;
         REG_SEGS: cfg_segs = value & 127;
         REG_COEFS: cfg_coefs = value & 15;
         default: ;
      endcase
   endtask

   // load every table entry not yet loaded that an evaluate may read under the current setting
   task automatic fill_tables();
      int naxes;
      int nseg;
      int ncoef;
      naxes = clamp_int(cfg_axes, 1, MAX_AXES);
      nseg = clamp_int(cfg_segs, 1, MAX_SEGMENTS);
      ncoef = clamp_int(cfg_coefs, 1, MAX_COEFFICIENTS);
      for (int a = 0; a < naxes; a++)
         for (int s = 0; s < nseg; s++) begin
            if (!dur_ok[a][s]) push_req(OP_LOAD_DUR, a, s, 0, pick_duration(), 0, 0);
            for (int c = 0; c < ncoef; c++)
               if (!coef_ok[a][s][c]) push_req(OP_LOAD_COEF, a, s, c, pick_coef(), 0, 0);
         end
   endtask

   task automatic random_items(int count);
      int nseg;
      int r;
      logic [31:0] t;
      nseg = clamp_int(cfg_segs, 1, MAX_SEGMENTS);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 20) begin
            push_req(OP_LOAD_COEF, $urandom_range(0, 3), $urandom_range(0, 63),
                     $urandom_range(0, 7), pick_coef(), $urandom, $urandom_range(0, 7));
         end else if (r < 32) begin
            push_req(OP_LOAD_DUR, $urandom_range(0, 3), $urandom_range(0, 63),
                     $urandom_range(0, 7), pick_duration(), $urandom, $urandom_range(0, 7));
         end else if (r < 35) begin
            push_req(OP_UNUSED, $urandom_range(0, 3), $urandom_range(0, 63),
                     $urandom_range(0, 7), $urandom, $urandom, $urandom_range(0, 7));
         end else begin
            r = $urandom_range(0, 19);
            if (r < 12) t = $urandom_range(0, nseg * 32'h30000);
            else if (r < 17) t = $urandom;
            else t = $urandom_range(0, 32'h100);
            push_req(OP_EVAL, $urandom_range(0, 3), $urandom_range(0, 63),
                     $urandom_range(0, 7), $urandom, t, $urandom_range(0, 7));
         end
         fill_tables();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;

      // reset setting: 3 axes, 1 segment, 8 coefficients
      for (int a = 0; a < 4; a++) push_req(OP_LOAD_DUR, a, 0, 0, 32'h0001_0000, 0, 0);
      push_req(OP_LOAD_DUR, 1, 0, 0, 32'h0, 0, 0);
      push_req(OP_LOAD_DUR, 2, 0, 0, 32'hFFFF_0000, 0, 0);
      push_req(OP_LOAD_COEF, 0, 0, 7, 32'h7FFF_FFFF, 0, 0);
      push_req(OP_LOAD_COEF, 1, 0, 0, 32'h8000_0000, 0, 0);
      fill_tables();
      push_req(OP_UNUSED, 3, 63, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7);
      push_req(OP_EVAL, 0, 0, 0, 0, 32'h0, 0);
      push_req(OP_EVAL, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
      for (int d = 1; d < 8; d++) push_req(OP_EVAL, 0, 0, 0, 0, 32'h0000_8000, d);
      push_req(OP_EVAL, 0, 0, 0, 0, 32'h0003_0000, 7);
      wait_drained();

      write_csr(REG_COEFS, 3);
      push_req(OP_EVAL, 0, 0, 0, 0, 32'h0000_C000, 3);
      push_req(OP_EVAL, 0, 0, 0, 0, 32'h0000_C000, 2);
      random_items(20);
      wait_drained();

      // long trajectory on one axis
      write_csr(REG_AXES, 1);
      write_csr(REG_SEGS, 16);
      write_csr(REG_COEFS, 2);
      fill_tables();
      random_items(20);
      // pause until every result is in, then go on
      wait_drained();
      random_items(15);
      wait_drained();

      write_csr(REG_AXES, 4);
      write_csr(REG_SEGS, 2);
      write_csr(REG_COEFS, 8);
      fill_tables();
      random_items(30);
      wait_drained();

      write_csr(REG_AXES, 2);
      write_csr(REG_SEGS, 8);
      write_csr(REG_COEFS, 1);
      fill_tables();
      random_items(15);
      wait_drained();

      write_csr(REG_AXES, 0);
      write_csr(REG_SEGS, 0);
      write_csr(REG_COEFS, 0);
      fill_tables();
      random_items(10);
      wait_drained();

      // register values above range on tables already loaded
      write_csr(REG_AXES, 7);
      write_csr(REG_SEGS, 2);
      write_csr(REG_COEFS, 15);
      fill_tables();
      random_items(15);
      wait_drained();
      repeat (50) @(posedge clock);

      if (errors == 0 && axis_results_q.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
